FILE: hdl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsd assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsd assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/hsd_pkg.sv
package hsd_pkg;

    localparam int CFG_W     = 7;
    localparam int TIME_W    = 32;
    localparam int ROT_W     = 32;
    localparam int SECTOR_W  = 4;
    localparam int DIR_W     = 2;
    localparam int ANGLE_W   = 35;
    localparam int VEL_W     = 27;
    localparam int SIXPP_W   = 10;                 // 6 * 127 fits
    localparam int DEN_W     = SIXPP_W + TIME_W;   // 6 * pp * period
    localparam int K_W       = 39;                 // 2*pi*1e6 in Q16.16
    localparam int REM_W     = DEN_W + 1;
    localparam int CNT_W     = 6;

    localparam logic [CFG_W-1:0] PP_RESET  = 7'd7;
    localparam logic [K_W-1:0]   VEL_K     = 39'd411774832291;
    localparam logic [K_W-1:0]   VEL_LIMIT = 39'd65536000;

    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sd0;
    localparam logic signed [DIR_W-1:0] DIR_CW   = 2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_CCW  = -2'sd1;

    localparam logic signed [SECTOR_W-1:0] SECTOR_BAD = -4'sd1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    function automatic logic signed [SECTOR_W-1:0] sector_of(input logic [2:0] code);
        logic signed [SECTOR_W-1:0] s;
        case (code)
            3'd1:    s = 4'sd0;
            3'd2:    s = 4'sd4;
            3'd3:    s = 4'sd5;
            3'd4:    s = 4'sd2;
            3'd5:    s = 4'sd1;
            3'd6:    s = 4'sd3;
            default: s = SECTOR_BAD;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/hsd_in_if.sv
interface hsd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            hall_a;
    logic                            hall_b;
    logic                            hall_c;
    logic [hsd_pkg::TIME_W-1:0]      time_us;

    modport source (output valid, hall_a, hall_b, hall_c, time_us, input ready);
    modport sink   (input valid, hall_a, hall_b, hall_c, time_us, output ready);
endinterface

FILE: hdl/hsd_out_if.sv
interface hsd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [hsd_pkg::SECTOR_W-1:0]   sector;
    logic signed [hsd_pkg::DIR_W-1:0]      turn_direction;
    logic signed [hsd_pkg::ROT_W-1:0]      rotations;
    logic signed [hsd_pkg::ANGLE_W-1:0]    angle_count;
    logic        [hsd_pkg::TIME_W-1:0]     period_us;
    logic signed [hsd_pkg::VEL_W-1:0]      velocity;
    logic                                  changed;

    modport source (output valid, sector, turn_direction, rotations, angle_count,
                    period_us, velocity, changed, input ready);
    modport sink   (input valid, sector, turn_direction, rotations, angle_count,
                    period_us, velocity, changed, output ready);
endinterface

FILE: hdl/hall_sensor_position_decoder_core.sv
// Hall sensor position decoder. Each input beat carries the three hall levels
// (A weight 4, B weight 2, C weight 1) and a free-running microsecond stamp; each
// beat yields exactly one output beat with sector, direction, rotation count,
// angle count (rotations*6 + sector), the last edge period and a signed Q16.16
// velocity in rad/s. A hall code change moves the position and stamps the edge;
// an unchanged code leaves the state alone but the velocity is still checked
// for staleness against the new stamp. Each beat goes from acceptance to the
// output register through the update step, the denominator multiply, 39 steps
// of a restoring divider and the result step, or skips the divider when the
// velocity is forced to zero (zero or stale period, unknown direction, zero pole
// pairs). The input is taken again in the idle cycle that follows, so a new beat
// is taken only after the last one has left the result step; a finished beat
// waits in the output register meanwhile, so the next item can be accepted while
// it is unread, and only a second finished beat holds the sequencer in its result
// step. The pole pair count, written through i_cfg_we / i_cfg_wdata, resets to 7;
// the user must write it while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module hall_sensor_position_decoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hsd_pkg::CFG_W-1:0]      i_cfg_wdata,
    hsd_in_if.sink                         i_in,
    hsd_out_if.source                      o_out
);

    // sequencer
    hsd_pkg::t_state r_state, n_state;

    // config
    logic [hsd_pkg::CFG_W-1:0] r_pp;

    // captured input beat
    logic [2:0]                    r_in_code;
    logic [hsd_pkg::TIME_W-1:0]    r_in_time;

    // decoder state
    logic [2:0]                              r_code;
    logic signed [hsd_pkg::SECTOR_W-1:0]     r_sector;
    logic [hsd_pkg::ROT_W-1:0]               r_rot;
    logic signed [hsd_pkg::DIR_W-1:0]        r_dir;
    logic [hsd_pkg::TIME_W-1:0]              r_edge_time;
    logic [hsd_pkg::TIME_W-1:0]              r_period;
    logic                                    r_changed;

    // divider
    logic [hsd_pkg::DEN_W-1:0]   r_den;
    logic [hsd_pkg::REM_W-1:0]   r_rem;
    logic [hsd_pkg::K_W-1:0]     r_quo;
    logic [hsd_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_zero;

    // output register
    logic                                    r_out_valid;
    logic signed [hsd_pkg::SECTOR_W-1:0]     r_out_sector;
    logic signed [hsd_pkg::DIR_W-1:0]        r_out_dir;
    logic [hsd_pkg::ROT_W-1:0]               r_out_rot;
    logic [hsd_pkg::ANGLE_W-1:0]             r_out_angle;
    logic [hsd_pkg::TIME_W-1:0]              r_out_period;
    logic [hsd_pkg::VEL_W-1:0]               r_out_vel;
    logic                                    r_out_changed;

    logic in_fire;
    logic out_free;

    // update-step logic
    logic signed [hsd_pkg::SECTOR_W-1:0]   upd_sector;
    logic signed [hsd_pkg::SECTOR_W:0]     upd_delta;
    logic signed [hsd_pkg::DIR_W-1:0]      upd_dir;
    logic [hsd_pkg::ROT_W-1:0]             upd_rot;

    // multiply-step logic
    logic [hsd_pkg::SIXPP_W-1:0]   six_pp;
    logic [hsd_pkg::DEN_W-1:0]     den_c;
    logic [hsd_pkg::TIME_W-1:0]    elapsed;
    logic                          zero_c;

    // divide-step logic
    logic [hsd_pkg::REM_W-1:0]     rem_sh;
    logic                          q_bit;

    // result logic
    logic [hsd_pkg::ANGLE_W-1:0]   rot_x;
    logic [hsd_pkg::ANGLE_W-1:0]   angle_c;
    logic [hsd_pkg::VEL_W-1:0]     vel_c;

    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == hsd_pkg::S_IDLE);

    // Direction and wrap: a jump of more than 3 sectors crosses the 5/0 boundary.
    assign upd_sector = hsd_pkg::sector_of(r_in_code);
    assign upd_delta  = {upd_sector[hsd_pkg::SECTOR_W-1], upd_sector}
                      - {r_sector[hsd_pkg::SECTOR_W-1], r_sector};

    always_comb begin
        upd_rot = r_rot;
        if (upd_delta > 5'sd3) begin
            upd_dir = hsd_pkg::DIR_CCW;
            upd_rot = r_rot - 32'd1;
        end else if (upd_delta < -5'sd3) begin
            upd_dir = hsd_pkg::DIR_CW;
            upd_rot = r_rot + 32'd1;
        end else if (upd_sector > r_sector) begin
            upd_dir = hsd_pkg::DIR_CW;
        end else begin
            upd_dir = hsd_pkg::DIR_CCW;
        end
    end

    // 6 * pp * period; a zero pole pair count gives a zero divisor.
    assign six_pp  = {1'b0, r_pp, 2'b00} + {2'b00, r_pp, 1'b0};
    assign den_c   = {{hsd_pkg::TIME_W{1'b0}}, six_pp} * {{hsd_pkg::SIXPP_W{1'b0}}, r_period};
    assign elapsed = r_in_time - r_edge_time;
    assign zero_c  = (r_period == '0) || (elapsed > r_period) || (r_pp == '0)
                   || (r_dir == hsd_pkg::DIR_NONE);

    // One restoring division step per cycle; the dividend shifts out of r_quo.
    assign rem_sh = {r_rem[hsd_pkg::REM_W-2:0], r_quo[hsd_pkg::K_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    // angle = rot*6 + sector, in 35-bit two's complement
    assign rot_x   = {{(hsd_pkg::ANGLE_W-hsd_pkg::ROT_W){r_rot[hsd_pkg::ROT_W-1]}}, r_rot};
    assign angle_c = (rot_x << 2) + (rot_x << 1)
                   + {{(hsd_pkg::ANGLE_W-hsd_pkg::SECTOR_W){r_sector[hsd_pkg::SECTOR_W-1]}},
                      r_sector};

    always_comb begin
        if (r_zero || (r_quo > hsd_pkg::VEL_LIMIT)) begin
            vel_c = '0;
        end else if (r_dir == hsd_pkg::DIR_CCW) begin
            vel_c = '0 - r_quo[hsd_pkg::VEL_W-1:0];
        end else begin
            vel_c = r_quo[hsd_pkg::VEL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hsd_pkg::S_IDLE: begin
                if (in_fire) n_state = hsd_pkg::S_UPD;
            end
            hsd_pkg::S_UPD:  n_state = hsd_pkg::S_MUL;
            hsd_pkg::S_MUL:  n_state = zero_c ? hsd_pkg::S_DONE : hsd_pkg::S_DIV;
            hsd_pkg::S_DIV: begin
                if (r_cnt == hsd_pkg::CNT_W'(1)) n_state = hsd_pkg::S_DONE;
            end
            hsd_pkg::S_DONE: begin
                if (out_free) n_state = hsd_pkg::S_IDLE;
            end
            default:         n_state = hsd_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsd_pkg::S_IDLE;
            r_pp        <= hsd_pkg::PP_RESET;
            r_code      <= '0;
            r_sector    <= '0;
            r_rot       <= '0;
            r_dir       <= hsd_pkg::DIR_NONE;
            r_edge_time <= '0;
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_pp <= i_cfg_wdata;
            if (r_state == hsd_pkg::S_UPD && r_in_code != r_code) begin
                r_code      <= r_in_code;
                r_sector    <= upd_sector;
                r_rot       <= upd_rot;
                r_dir       <= upd_dir;
                r_period    <= (upd_dir == r_dir) ? (r_in_time - r_edge_time) : '0;
                r_edge_time <= r_in_time;
            end
            if (r_state == hsd_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_code <= {i_in.hall_a, i_in.hall_b, i_in.hall_c};
            r_in_time <= i_in.time_us;
        end
        if (r_state == hsd_pkg::S_UPD) begin
            r_changed <= (r_in_code != r_code);
        end
        if (r_state == hsd_pkg::S_MUL) begin
            r_den  <= den_c;
            r_rem  <= '0;
            r_quo  <= hsd_pkg::VEL_K;
            r_cnt  <= hsd_pkg::CNT_W'(hsd_pkg::K_W);
            r_zero <= zero_c;
        end
        if (r_state == hsd_pkg::S_DIV) begin
            r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[hsd_pkg::K_W-2:0], q_bit};
            r_cnt <= r_cnt - hsd_pkg::CNT_W'(1);
        end
        if (r_state == hsd_pkg::S_DONE && out_free) begin
            r_out_sector  <= r_sector;
            r_out_dir     <= r_dir;
            r_out_rot     <= r_rot;
            r_out_angle   <= angle_c;
            r_out_period  <= r_period;
            r_out_vel     <= vel_c;
            r_out_changed <= r_changed;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sector         = r_out_sector;
    assign o_out.turn_direction = r_out_dir;
    assign o_out.rotations      = r_out_rot;
    assign o_out.angle_count    = r_out_angle;
    assign o_out.period_us      = r_out_period;
    assign o_out.velocity       = r_out_vel;
    assign o_out.changed        = r_out_changed;

    // accepted beat always starts the update step and closes the input
    `ASSERT_NEXT(a_accept_to_upd, i_clk, i_rst_n, in_fire,
                 (r_state == hsd_pkg::S_UPD) && !i_in.ready)
    // a new result only comes out of the result step
    `ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid),
                 $past(r_state == hsd_pkg::S_DONE))
    // divider never runs with an exhausted step count
    `ASSERT_IMPL(a_div_count, i_clk, i_rst_n, r_state == hsd_pkg::S_DIV,
                 r_cnt != '0)
    // unknown direction always reports zero speed
    `ASSERT_IMPL(a_vel_dir, i_clk, i_rst_n,
                 r_out_valid && (r_out_dir == hsd_pkg::DIR_NONE), r_out_vel == '0)

endmodule
